// File: hdl/fofp_pkg.sv
`timescale 1ns / 1ps
// fofp_pkg: shared types and constants of the fixed-offset frame parser
// byte offsets, tag codes, message and command codes, result struct; no dependencies

package fofp_pkg;

    localparam int unsigned POS_W = 16;

    localparam logic [7:0] DOLLAR = 8'h24;

    // fixed byte offsets within a frame
    localparam logic [POS_W-1:0] POS_DELIM0   = 16'd0;
    localparam logic [POS_W-1:0] POS_DELIM1   = 16'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 16'd9;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 16'd10;
    localparam logic [POS_W-1:0] POS_TYPE_END = 16'd20;
    localparam logic [POS_W-1:0] POS_SND_TLO  = 16'd30;
    localparam logic [POS_W-1:0] POS_SND_THI  = 16'd31;
    localparam logic [POS_W-1:0] POS_CMD_END  = 16'd34;
    localparam logic [POS_W-1:0] POS_SEND_TLO = 16'd44;
    localparam logic [POS_W-1:0] POS_SEND_THI = 16'd45;

    // payload start offsets
    localparam logic [5:0] START_SND  = 6'd34;
    localparam logic [5:0] START_SEND = 6'd48;
    localparam logic [5:0] START_CMD  = 6'd37;

    // ascii type tags, three bytes, first byte in the top
    localparam logic [23:0] TAG_CMD = 24'h434D44;
    localparam logic [23:0] TAG_ACK = 24'h41434B;
    localparam logic [23:0] TAG_SND = 24'h534E44;

    // ascii command tags, four bytes, first byte in the top
    localparam logic [31:0] TAG_TIME = 32'h54494D45;
    localparam logic [31:0] TAG_NAME = 32'h4E414D45;
    localparam logic [31:0] TAG_LIST = 32'h4C495354;
    localparam logic [31:0] TAG_CONN = 32'h434F4E4E;
    localparam logic [31:0] TAG_SEND = 32'h53454E44;
    localparam logic [31:0] TAG_DISC = 32'h44495343;

    // message kind codes
    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_ACK = 2'd1;
    localparam logic [1:0] KIND_SND = 2'd2;

    // command codes
    localparam logic [2:0] CMD_TIME = 3'd0;
    localparam logic [2:0] CMD_NAME = 3'd1;
    localparam logic [2:0] CMD_LIST = 3'd2;
    localparam logic [2:0] CMD_CONN = 3'd3;
    localparam logic [2:0] CMD_SEND = 3'd4;
    localparam logic [2:0] CMD_DISC = 3'd5;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             payload_valid;
        logic             frame_done;
        logic             frame_ok;
        logic [1:0]       message_kind;
        logic [2:0]       command_kind;
        logic [15:0]      target_id;
        logic [POS_W-1:0] declared_length;
    } t_result;

endpackage

// File: hdl/fofp_core.sv
`timescale 1ns / 1ps
// fofp_core: per-frame parse state and the single-pass decode of one byte
// depends on fofp_pkg

module fofp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output fofp_pkg::t_result o_result
);
    import fofp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_target, n_target;
    logic [23:0]      r_tag, n_tag_keep;
    logic [1:0]       r_kind, n_kind;
    logic [2:0]       r_cmd, n_cmd;
    logic             r_good, n_good;
    logic [7:0]       r_prev, n_prev;

    logic [31:0]      w_tag;
    logic [1:0]       w_kind_dec;
    logic             w_kind_bad;
    logic [2:0]       w_cmd_dec;
    logic             w_cmd_found;
    logic             w_snd_layout;
    logic [5:0]       w_start;
    logic [16:0]      w_count;
    logic             w_pay;
    logic             w_ok;

    assign w_tag = {r_tag, i_byte};

    // type tag lookup
    always_comb begin
        w_kind_bad = 1'b0;
        case (w_tag[23:0])
            TAG_CMD: w_kind_dec = KIND_CMD;
            TAG_ACK: w_kind_dec = KIND_ACK;
            TAG_SND: w_kind_dec = KIND_SND;
            default: begin
                w_kind_dec = KIND_SND;
                w_kind_bad = 1'b1;
            end
        endcase
    end

    // command tag lookup
    always_comb begin
        w_cmd_found = 1'b1;
        case (w_tag)
            TAG_TIME: w_cmd_dec = CMD_TIME;
            TAG_NAME: w_cmd_dec = CMD_NAME;
            TAG_LIST: w_cmd_dec = CMD_LIST;
            TAG_CONN: w_cmd_dec = CMD_CONN;
            TAG_SEND: w_cmd_dec = CMD_SEND;
            TAG_DISC: w_cmd_dec = CMD_DISC;
            default: begin
                w_cmd_dec   = CMD_TIME;
                w_cmd_found = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_good   = r_good;
        n_len    = r_len;
        n_kind   = r_kind;
        n_cmd    = r_cmd;
        n_target = r_target;

        if ((r_pos == POS_DELIM0 || r_pos == POS_DELIM1) && i_byte != DOLLAR) begin
            n_good = 1'b0;
        end
        if (r_pos == POS_LEN_LO) begin
            n_len = {r_len[15:8], i_byte};
        end
        if (r_pos == POS_LEN_HI) begin
            n_len = {i_byte, r_len[7:0]};
        end
        if (r_pos == POS_TYPE_END) begin
            n_kind = w_kind_dec;
            if (w_kind_bad) begin
                n_good = 1'b0;
            end
        end

        w_snd_layout = (n_kind != KIND_CMD) && (n_kind != KIND_ACK);

        if (w_snd_layout) begin
            if (r_pos == POS_SND_TLO) begin
                n_target = {r_target[15:8], i_byte};
            end
            if (r_pos == POS_SND_THI) begin
                n_target = {i_byte, r_target[7:0]};
            end
        end else begin
            if (r_pos == POS_CMD_END) begin
                n_cmd = w_cmd_dec;
                if (!w_cmd_found) begin
                    n_good = 1'b0;
                end
            end
            if (n_cmd == CMD_SEND) begin
                if (r_pos == POS_SEND_TLO) begin
                    n_target = {r_target[15:8], i_byte};
                end
                if (r_pos == POS_SEND_THI) begin
                    n_target = {i_byte, r_target[7:0]};
                end
            end
        end

        if (w_snd_layout) begin
            w_start = START_SND;
        end else if (n_cmd == CMD_SEND) begin
            w_start = START_SEND;
        end else begin
            w_start = START_CMD;
        end

        w_pay   = (r_pos >= {10'd0, w_start}) &&
                  (({1'b0, r_pos} + 17'd3) <= {1'b0, n_len});
        w_count = {1'b0, r_pos} + 17'd1;
        w_ok    = n_good && (r_prev == DOLLAR) && (i_byte == DOLLAR) &&
                  (w_count == {1'b0, n_len}) &&
                  (w_count >= ({11'd0, w_start} + 17'd2));
    end

    // result fields
    always_comb begin
        o_result                 = '0;
        o_result.payload_valid   = w_pay;
        o_result.payload_byte    = w_pay ? i_byte : 8'd0;
        o_result.frame_done      = i_last;
        if (i_last) begin
            o_result.frame_ok        = w_ok;
            o_result.message_kind    = n_kind;
            o_result.command_kind    = w_snd_layout ? CMD_TIME : n_cmd;
            o_result.target_id       = (w_snd_layout || n_cmd == CMD_SEND) ? n_target : 16'd0;
            o_result.declared_length = n_len;
        end
    end

    // position saturates at all ones
    assign n_pos      = (r_pos == '1) ? r_pos : r_pos + 16'd1;
    assign n_tag_keep = w_tag[23:0];
    assign n_prev     = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_target <= '0;
            r_tag    <= '0;
            r_kind   <= KIND_CMD;
            r_cmd    <= CMD_TIME;
            r_good   <= 1'b1;
            r_prev   <= '0;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_target <= n_target;
            r_tag    <= n_tag_keep;
            r_kind   <= n_kind;
            r_cmd    <= n_cmd;
            r_good   <= n_good;
            r_prev   <= n_prev;
        end
    end

endmodule

// File: hdl/fixed_offset_frame_parser.sv
`timescale 1ns / 1ps
// fixed_offset_frame_parser: top level with input register, parse core and result register
// depends on fofp_pkg and fofp_core

// Parses one frame at a time, one byte per input transaction, with i_last_byte on the final
// byte. Every byte gives exactly one result transaction: payload bytes from the payload
// offset up to declared length minus 3 come out with o_payload_valid set, and the result for
// the last byte carries o_frame_done with the frame verdict (delimiters, length, type,
// command, minimum size), the decoded message and command kinds, the target id and the
// declared length. Sustained rate is one byte per clock while i_out_ready stays high; each
// byte passes through the input register, then the result register, before its result is
// valid. The only loop is the per-frame state update in the parse core. o_in_ready depends
// combinationally on i_out_ready through the result register; the block holds one byte in
// its input register while a finished result waits.

module fixed_offset_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_frame_done,
    output logic        o_frame_ok,
    output logic [1:0]  o_message_kind,
    output logic [2:0]  o_command_kind,
    output logic [15:0] o_target_id,
    output logic [15:0] o_declared_length
);
    import fofp_pkg::*;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic       r_out_valid, n_out_valid;
    t_result    r_out;

    logic       w_advance;
    t_result    w_result;

    // a byte moves from the input register through the core when the result slot frees
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    assign n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !w_advance);
    assign n_out_valid = w_advance || (r_out_valid && !i_out_ready);

    fofp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_payload_valid   = r_out.payload_valid;
    assign o_frame_done      = r_out.frame_done;
    assign o_frame_ok        = r_out.frame_ok;
    assign o_message_kind    = r_out.message_kind;
    assign o_command_kind    = r_out.command_kind;
    assign o_target_id       = r_out.target_id;
    assign o_declared_length = r_out.declared_length;

    // a held byte is neither dropped nor overwritten while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input byte lost or overwritten while stalled");

    // a frame verdict only appears on the last byte of a frame
    a_ok_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ok |-> o_frame_done)
        else $error("frame_ok set outside frame_done");

    // summary fields stay zero on results that do not end a frame
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_done |->
            o_declared_length == 16'd0 && o_target_id == 16'd0 &&
            o_message_kind == KIND_CMD && o_command_kind == CMD_TIME)
        else $error("summary fields nonzero before frame end");

endmodule
